/* src/cwc_pkg.sv */
// Shared types and constants for the congestion window controller.
`default_nettype none
package cwc_pkg;
   localparam int WIN_W = 24;
   localparam int SEQ_W = 32;
   localparam logic [WIN_W-1:0] WIN_MAX = 24'hFFFFFF;

   typedef enum logic [1:0] {
      CMD_DATA    = 2'd0,
      CMD_TIMEOUT = 2'd1,
      CMD_NACK    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      RSN_CONGESTION = 2'd0,
      RSN_BUSY       = 2'd1,
      RSN_FREE       = 2'd2,
      RSN_OTHER      = 2'd3
   } reason_type;

   localparam logic [1:0] MODE_AIMD = 2'd0;
   localparam logic [1:0] MODE_ECP  = 2'd1;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_BETA  = 2'd1;
   localparam logic [1:0] REG_INIT  = 2'd2;
   localparam logic [1:0] REG_FLOOR = 2'd3;

   // Front-end classification of one request.
   typedef enum logic [2:0] {
      OP_REPORT   = 3'd0,
      OP_GROW     = 3'd1,
      OP_SHRINK_T = 3'd2,
      OP_SHRINK_N = 3'd3,
      OP_HELD     = 3'd4,
      OP_ADJ_SET  = 3'd5,
      OP_ADJ_CLR  = 3'd6
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [SEQ_W-1:0] seq_num;
      logic [SEQ_W-1:0] next_seq;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DIV    = 3'd1,
      ST_MUL    = 3'd2,
      ST_FLOOR  = 3'd3,
      ST_OUT    = 3'd4
   } back_state_type;
endpackage
`default_nettype wire

/* src/cwc_if.sv */
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface cwc_req_if import cwc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       command;
   logic [SEQ_W-1:0] seq_num;
   logic [SEQ_W-1:0] next_seq;
   logic [1:0]       nack_reason;
   modport source (output valid, command, seq_num, next_seq, nack_reason, input ready);
   modport sink (input valid, command, seq_num, next_seq, nack_reason, output ready);
endinterface

interface cwc_rsp_if import cwc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] window_out;
   logic [WIN_W-1:0] threshold_out;
   logic             decreased;
   logic             suppressed;
   modport source (output valid, window_out, threshold_out, decreased, suppressed,
                   input ready);
   modport sink (input valid, window_out, threshold_out, decreased, suppressed,
                 output ready);
endinterface
`default_nettype wire

/* src/cwc_front.sv */
// Front end: accepts requests, keeps the nacked-sequence table, classifies.
`default_nettype none
module cwc_front import cwc_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   cwc_req_if.sink            req,
   input  wire logic [1:0]    mode,
   output job_type            job,
   output logic               job_valid,
   input  wire logic          job_ready
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [SEQ_W-1:0] seq_ff [DEPTH];
   logic [PW-1:0]    wp_ff, wp_in;
   logic             busy_ff, busy_in;
   job_type          job_ff, job_in;
   logic [DEPTH-1:0] hit;
   logic             do_insert;

   assign req.ready = !busy_ff || job_ready;
   assign job       = job_ff;
   assign job_valid = busy_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = vld_ff[i] && (seq_ff[i] == req.seq_num);
      end
   end

   always_comb begin
      vld_in    = vld_ff;
      wp_in     = wp_ff;
      busy_in   = busy_ff && !job_ready;
      job_in    = job_ff;
      do_insert = 1'b0;
      if (req.valid && req.ready) begin
         busy_in         = 1'b1;
         job_in.seq_num  = req.seq_num;
         job_in.next_seq = req.next_seq;
         job_in.op       = OP_REPORT;
         case (cmd_type'(req.command))
            CMD_DATA: job_in.op = OP_GROW;
            CMD_TIMEOUT: begin
               if (|hit) begin
                  vld_in    = vld_ff & ~hit;
                  job_in.op = OP_HELD;
               end else begin
                  job_in.op = OP_SHRINK_T;
               end
            end
            CMD_NACK: begin
               if (mode == MODE_ECP) begin
                  case (reason_type'(req.nack_reason))
                     RSN_FREE:       job_in.op = OP_ADJ_SET;
                     RSN_BUSY:       job_in.op = OP_ADJ_CLR;
                     RSN_CONGESTION: job_in.op = OP_SHRINK_N;
                     default:        job_in.op = OP_REPORT;
                  endcase
               end else if (mode == MODE_AIMD &&
                            req.nack_reason == RSN_CONGESTION) begin
                  job_in.op = OP_SHRINK_N;
                  if (!(|hit)) begin
                     do_insert     = 1'b1;
                     vld_in[wp_ff] = 1'b1;
                     wp_in         = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                  end
               end
            end
            default: job_in.op = OP_REPORT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         wp_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         wp_ff   <= wp_in;
         busy_ff <= busy_in;
      end
      job_ff <= job_in;
      if (do_insert) begin
         seq_ff[wp_ff] <= req.seq_num;
      end
   end

`ifndef ASSERT_OFF
   a_held_was_hit: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.command == CMD_TIMEOUT && |hit)
      |=> (job_ff.op == OP_HELD))
      else $error("table hit not classified as held");
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.command == CMD_TIMEOUT && |hit)
      |=> ((vld_ff & $past(hit)) == '0))
      else $error("hit entry still valid");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !job_ready) |=> (busy_ff && $stable(job_ff)))
      else $error("queued job lost");
`endif
endmodule
`default_nettype wire

/* src/cwc_back.sv */
// Back end: applies growth and decreases to the window, with a serial divider for 1/window growth.
`default_nettype none
module cwc_back import cwc_pkg::*; #(
   parameter int FRAC = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire job_type          job,
   input  wire logic             job_valid,
   output logic                  job_ready,
   input  wire logic [1:0]       mode,
   input  wire logic [7:0]       beta,
   input  wire logic [WIN_W-1:0] init_win,
   input  wire logic             floor_init,
   input  wire logic             load_win,
   cwc_rsp_if.source             rsp
);
   localparam int NW = 2 * FRAC + 1;
   localparam int CW = $clog2(NW + 1);
   localparam logic [WIN_W-1:0] ONE = WIN_W'(1) << FRAC;

   back_state_type   st_ff, st_in;
   logic [WIN_W-1:0] win_ff, win_in, thr_ff, thr_in, before_ff, before_in;
   logic [SEQ_W-1:0] high_ff, high_in, rec_ff, rec_in;
   logic             adj_ff, adj_in, held_ff, held_in;
   job_type          cur_ff, cur_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [WIN_W:0]   rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIN_W+7:0] prod_ff, prod_in;
   logic             ovalid_ff, ovalid_in;
   logic [WIN_W-1:0] owin_ff, owin_in, othr_ff, othr_in;
   logic             odec_ff, odec_in, osup_ff, osup_in;
   logic [WIN_W:0]   rem_sh, sum;
   logic [2*FRAC:0]  dividend;
   logic [WIN_W-1:0] red;

   assign dividend = (NW)'(1) << (2 * FRAC);
   assign job_ready = (st_ff == ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.window_out = owin_ff;
   assign rsp.threshold_out = othr_ff;
   assign rsp.decreased = odec_ff;
   assign rsp.suppressed = osup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         thr_ff    <= WIN_MAX;
         high_ff   <= '0;
         rec_ff    <= '0;
         adj_ff    <= 1'b1;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         thr_ff    <= thr_in;
         high_ff   <= high_in;
         rec_ff    <= rec_in;
         adj_ff    <= adj_in;
         ovalid_ff <= ovalid_in;
      end
      if (reset || load_win) begin
         win_ff <= init_win;
      end else begin
         win_ff <= win_in;
      end
      before_ff <= before_in;
      held_ff   <= held_in;
      cur_ff    <= cur_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      owin_ff   <= owin_in;
      othr_ff   <= othr_in;
      odec_ff   <= odec_in;
      osup_ff   <= osup_in;
   end

   always_comb begin
      st_in = st_ff; win_in = win_ff; thr_in = thr_ff; before_in = before_ff;
      high_in = high_ff; rec_in = rec_ff; adj_in = adj_ff; held_in = held_ff;
      cur_in = cur_ff; quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      prod_in = prod_ff; ovalid_in = ovalid_ff && !rsp.ready;
      owin_in = owin_ff; othr_in = othr_ff; odec_in = odec_ff; osup_in = osup_ff;
      rem_sh = {rem_ff[WIN_W-1:0], dividend[cnt_ff[CW-1:0] - 1'b1]};
      sum = '0;
      red = '0;
      case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               cur_in = job; before_in = win_ff; held_in = 1'b0;
               rem_in = '0; quo_in = '0; cnt_in = CW'(NW);
               st_in = ST_OUT;
               case (job.op)
                  OP_GROW: begin
                     if (high_ff < job.seq_num) high_in = job.seq_num;
                     if (mode == MODE_AIMD && win_ff < thr_ff) begin
                        sum = {1'b0, win_ff} + {1'b0, ONE};
                        win_in = sum[WIN_W] ? WIN_MAX : sum[WIN_W-1:0];
                     end else if (mode == MODE_ECP && adj_ff) begin
                        sum = {1'b0, win_ff} + {1'b0, ONE >> 1};
                        win_in = sum[WIN_W] ? WIN_MAX : sum[WIN_W-1:0];
                     end else if (mode == MODE_AIMD || mode == MODE_ECP) begin
                        st_in = ST_DIV;
                     end
                  end
                  OP_SHRINK_T, OP_SHRINK_N: begin
                     if (!(high_ff > rec_ff)) begin
                        held_in = 1'b1;
                     end else begin
                        rec_in = job.next_seq;
                        prod_in = {8'd0, win_ff} *
                                  {24'd0, ((job.op == OP_SHRINK_T) ? beta : 8'd224)};
                        st_in = ST_MUL;
                     end
                  end
                  OP_HELD:    held_in = 1'b1;
                  OP_ADJ_SET: adj_in = 1'b1;
                  OP_ADJ_CLR: adj_in = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            // restoring division of 1.0*1.0 by the window, one bit a cycle
            if (rem_sh >= {1'b0, win_ff}) begin
               rem_in = rem_sh - {1'b0, win_ff};
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               sum = {1'b0, win_ff} + ((win_ff == '0) ? {1'b0, ONE}
                                                        : (WIN_W+1)'(quo_in));
               win_in = sum[WIN_W] ? WIN_MAX : sum[WIN_W-1:0];
               st_in = ST_OUT;
            end
         end
         ST_MUL: begin
            if (mode == MODE_AIMD) begin
               red = (cur_ff.op == OP_SHRINK_N) ? (win_ff >> 1) : prod_ff[WIN_W+7:8];
               thr_in = red;
            end else if (mode == MODE_ECP) begin
               red = (cur_ff.op == OP_SHRINK_N) ? prod_ff[WIN_W+7:8] : (win_ff >> 1);
            end else begin
               red = win_ff;
            end
            win_in = red;
            st_in = ST_FLOOR;
         end
         ST_FLOOR: begin
            if (floor_init && win_ff < init_win) win_in = init_win;
            else if (win_ff < ONE) win_in = ONE;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ovalid_ff || rsp.ready) begin
               ovalid_in = 1'b1;
               owin_in = win_ff; othr_in = thr_ff;
               odec_in = win_ff < before_ff; osup_in = held_ff;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_held_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.suppressed && !$past(rsp.valid && !rsp.ready))
      |-> !rsp.decreased)
      else $error("suppressed response also decreased");
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !job_ready)
      else $error("back end took a job while busy");
   a_floor: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FLOOR) |=> (win_ff >= ONE || floor_init))
      else $error("window below one after decrease");
`endif
endmodule
`default_nettype wire

/* src/congestion_window_controller_core.sv */
// Top level of the congestion window controller.
// One request yields one response. A data, timeout or nack request that
// needs no reciprocal and no decrease goes straight to the response; growth by
// 1/window runs a one-bit-per-cycle restoring divider. A decrease either
// halves the window or scales it by one 24x8 multiply, then applies the floor.
// The front end keeps the nacked-sequence table and can hold one classified
// request while the back end works; the response sits in an output register.
// The window starts at the initial window's reset value; later csr writes to
// the initial window only move the floor applied after a decrease.
`default_nettype none
module congestion_window_controller_core import cwc_pkg::*; #(
   parameter int NACK_TABLE_DEPTH = 16,
   parameter int WINDOW_FRAC_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   cwc_req_if.sink               req,
   cwc_rsp_if.source             rsp,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [WIN_W-1:0] csr_wdata
);
   logic [1:0]       mode_ff;
   logic [7:0]       beta_ff;
   logic [WIN_W-1:0] init_ff;
   logic             floor_ff;
   job_type          job;
   logic             job_valid, job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_AIMD;
         beta_ff  <= 8'd128;
         init_ff  <= WIN_W'(1) << WINDOW_FRAC_BITS;
         floor_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE:  mode_ff  <= csr_wdata[1:0];
            REG_BETA:  beta_ff  <= csr_wdata[7:0];
            REG_INIT:  init_ff  <= csr_wdata;
            REG_FLOOR: floor_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   cwc_front #(.DEPTH(NACK_TABLE_DEPTH)) u_front (
      .clock, .reset, .req, .mode(mode_ff),
      .job, .job_valid, .job_ready
   );

   // reset window loads from the register's reset value, which is 1.0
   cwc_back #(.FRAC(WINDOW_FRAC_BITS)) u_back (
      .clock, .reset, .job, .job_valid, .job_ready,
      .mode(mode_ff), .beta(beta_ff), .init_win(init_ff), .floor_init(floor_ff),
      .load_win(1'b0), .rsp
   );
endmodule
`default_nettype wire
